[rtl/rpa_pkg.sv]
package rpa_pkg;

  // Sizing of the page store and the lists
  localparam int NUM_PAGES  = 2048;
  localparam int NUM_CPUS   = 2;
  localparam int COUNT_BITS = 8;

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // Fixed field widths of the command and result ports
  localparam int CMD_W      = 3;
  localparam int PAGE_W     = 11;
  localparam int REF_W      = 8;
  localparam int FREE_W     = 12;
  localparam int ERR_W      = 3;
  localparam int FIRST_W    = 11;
  localparam int LIMIT_W    = 12;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FREE_W-1:0]     FREE_MAX  = '1;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUM_PAGES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 3'd0,
    CMD_FREE       = 3'd1,
    CMD_ADD_REF    = 3'd2,
    CMD_GET_REF    = 3'd3,
    CMD_SEED       = 3'd4,
    CMD_FREE_COUNT = 3'd5
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_RANGE     = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_NO_MEMORY = 3'd4
  } err_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_SET_ONE,
    OP_INC,
    OP_DEC
  } cnt_op_e;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic                  rd_en;
    logic [IDX_W-1:0]      cnt_raddr;
    logic [IDX_W-1:0]      link_raddr;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    link_t                 link_wdata;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic             clearing;
    logic             accept;
    logic             exec;
    logic [IDX_W-1:0] clr_addr;
  } ctrl_t;

endpackage

[rtl/rpa_cnt_alu.sv]
module rpa_cnt_alu
  import rpa_pkg::*;
(
  input  cnt_op_e               op_i,
  input  logic [COUNT_BITS-1:0] old_i,
  output logic [COUNT_BITS-1:0] result_o,
  output logic                  underflow_o,
  output logic                  overflow_o
);

  always_comb begin
    result_o    = old_i;
    underflow_o = 1'b0;
    overflow_o  = 1'b0;
    case (op_i)
      OP_CLEAR:   result_o = '0;
      OP_SET_ONE: result_o = COUNT_BITS'(1);
      OP_INC: begin
        if (old_i == COUNT_MAX) begin
          overflow_o = 1'b1;
        end else begin
          result_o = old_i + 1'b1;
        end
      end
      OP_DEC: begin
        if (old_i == '0) begin
          underflow_o = 1'b1;
        end else begin
          result_o = old_i - 1'b1;
        end
      end
      default: result_o = old_i;
    endcase
  end

endmodule

[rtl/rpa_store.sv]
module rpa_store
  import rpa_pkg::*;
(
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [COUNT_BITS-1:0] cnt_rdata_o,
  output link_t                 link_rdata_o
);

  logic [COUNT_BITS-1:0] cnt_mem  [NUM_PAGES];
  link_t                 link_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_rdata_q;
  link_t                 link_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem[req_i.cnt_waddr] <= req_i.cnt_wdata;
    end
    if (req_i.rd_en) begin
      cnt_rdata_q <= cnt_mem[req_i.cnt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    if (req_i.rd_en) begin
      link_rdata_q <= link_mem[req_i.link_raddr];
    end
  end

  assign cnt_rdata_o  = cnt_rdata_q;
  assign link_rdata_o = link_rdata_q;

endmodule

[rtl/rpa_ctrl.sv]
module rpa_ctrl
  import rpa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output ctrl_t ctrl_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.clr_addr = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.clearing = 1'b1;
      end
      ST_IDLE:  ctrl_o.accept = start_i;
      ST_EXEC: begin
        ctrl_o.busy = 1'b1;
        ctrl_o.exec = 1'b1;
      end
      default:  ctrl_o.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule

[rtl/refcounted_page_allocator.sv]
// Flow: an accepted command runs in the execute state; done_o is registered from that state.
// Commands: busy is high while one executes, so the next command waits for it; the count and
//   link memories are read at acceptance and written back in the execute cycle that follows.
// Reset: lists empty, free total zero, first_page 0, page_limit 2048; a clearing pass then
//   zeroes all NUM_PAGES (2048) entries of the count memory with busy high.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module refcounted_page_allocator
  import rpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      command_i,
  input  logic                  cpu_i,
  input  logic [PAGE_W-1:0]     page_i,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // result channel
  output logic                  done_o,
  output logic                  ok_o,
  output logic [PAGE_W-1:0]     alloc_page_o,
  output logic [REF_W-1:0]      ref_count_o,
  output logic                  released_o,
  output logic [FREE_W-1:0]     free_pages_o,
  output logic [ERR_W-1:0]      error_code_o
);

  ctrl_t                 ctrl;
  mem_req_t              mem_req;
  logic [COUNT_BITS-1:0] cnt_rdata;
  link_t                 link_rdata;

  // Configuration registers
  logic [FIRST_W-1:0] first_page_q;
  logic [LIMIT_W-1:0] page_limit_q;

  // List state: one LIFO head per CPU plus its non-empty flag
  logic [IDX_W-1:0]    heads_q [NUM_CPUS];
  logic [NUM_CPUS-1:0] nonempty_q;
  logic [FREE_W-1:0]   free_total_q, free_total_d;

  // Transaction captured at acceptance
  logic [CMD_W-1:0]  cmd_q;
  logic [PAGE_W-1:0] page_q;
  logic [CPU_W-1:0]  sel_q;
  logic [IDX_W-1:0]  sel_head_q;
  logic              sel_nonempty_q;
  logic              oom_q;

  // Result registers
  logic              done_q;
  logic              ok_q;
  logic [PAGE_W-1:0] alloc_page_q;
  logic [REF_W-1:0]  ref_count_q;
  logic              released_q;
  logic [ERR_W-1:0]  error_code_q;

  // Acceptance-side selection
  logic [CPU_W-1:0] cpu_sel;
  logic [CPU_W-1:0] steal_idx;
  logic             steal_found;
  logic [CPU_W-1:0] src_sel;
  logic [CPU_W-1:0] rd_sel;
  logic             oom_d;

  // Execute-side decisions
  cnt_op_e               alu_op;
  logic [COUNT_BITS-1:0] alu_result;
  logic                  alu_under;
  logic                  alu_over;
  logic                  in_range;
  logic                  ex_cnt_we;
  logic [IDX_W-1:0]      ex_cnt_waddr;
  logic                  ex_push;
  logic                  ex_pop;
  logic                  ex_ok;
  logic [IDX_W-1:0]      ex_apage;
  logic [COUNT_BITS-1:0] ex_cnt;
  logic                  ex_rel;
  err_e                  ex_err;

  rpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .ctrl_o (ctrl)
  );

  assign busy = ctrl.busy;

  // Pick the local list, else steal from the lowest-numbered other non-empty list.
  assign cpu_sel = (NUM_CPUS == 1) ? '0 : CPU_W'(cpu_i);

  always_comb begin
    steal_found = 1'b0;
    steal_idx   = '0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (!steal_found && (CPU_W'(i) != cpu_sel) && nonempty_q[i]) begin
        steal_found = 1'b1;
        steal_idx   = CPU_W'(i);
      end
    end
  end

  assign src_sel = nonempty_q[cpu_sel] ? cpu_sel : steal_idx;
  assign oom_d   = !nonempty_q[cpu_sel] && !steal_found;
  // Alloc works on the source list, every push on the requester's own list.
  assign rd_sel  = (command_i == CMD_ALLOC) ? src_sel : cpu_sel;

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      cmd_q          <= command_i;
      page_q         <= page_i;
      sel_q          <= rd_sel;
      sel_head_q     <= heads_q[rd_sel];
      sel_nonempty_q <= nonempty_q[rd_sel];
      oom_q          <= oom_d;
    end
  end

  rpa_cnt_alu u_alu (
    .op_i       (alu_op),
    .old_i      (cnt_rdata),
    .result_o   (alu_result),
    .underflow_o(alu_under),
    .overflow_o (alu_over)
  );

  assign in_range = (page_q >= first_page_q)
                 && ({1'b0, page_q} < page_limit_q)
                 && (32'(page_q) < 32'(NUM_PAGES));

  // Decode the captured command against the counts read at acceptance.
  always_comb begin
    alu_op       = ctrl.clearing ? OP_CLEAR : OP_HOLD;
    ex_cnt_we    = 1'b0;
    ex_cnt_waddr = IDX_W'(page_q);
    ex_push      = 1'b0;
    ex_pop       = 1'b0;
    ex_ok        = 1'b0;
    ex_apage     = '0;
    ex_cnt       = '0;
    ex_rel       = 1'b0;
    ex_err       = ERR_NONE;
    if (ctrl.exec) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (oom_q) begin
            ex_err = ERR_NO_MEMORY;
          end else begin
            alu_op       = OP_SET_ONE;
            ex_pop       = 1'b1;
            ex_cnt_we    = 1'b1;
            ex_cnt_waddr = sel_head_q;
            ex_apage     = sel_head_q;
            ex_cnt       = alu_result;
            ex_ok        = 1'b1;
          end
        end
        CMD_FREE: begin
          alu_op = OP_DEC;
          if (!in_range) begin
            ex_err = ERR_RANGE;
          end else if (alu_under) begin
            ex_err = ERR_UNDERFLOW;
          end else begin
            ex_cnt_we = 1'b1;
            ex_cnt    = alu_result;
            ex_ok     = 1'b1;
            if (alu_result == '0) begin
              ex_push = 1'b1;
              ex_rel  = 1'b1;
            end
          end
        end
        CMD_ADD_REF: begin
          alu_op = OP_INC;
          if (!in_range) begin
            ex_err = ERR_RANGE;
          end else begin
            // Saturated count reads back unchanged.
            ex_cnt = alu_result;
            if (alu_over) begin
              ex_err = ERR_OVERFLOW;
            end else begin
              ex_cnt_we = 1'b1;
              ex_ok     = 1'b1;
            end
          end
        end
        CMD_GET_REF: begin
          if (!in_range) begin
            ex_err = ERR_RANGE;
          end else begin
            ex_cnt = cnt_rdata;
            ex_ok  = 1'b1;
          end
        end
        CMD_SEED: begin
          alu_op = OP_CLEAR;
          if (!in_range) begin
            ex_err = ERR_RANGE;
          end else begin
            ex_cnt_we = 1'b1;
            ex_cnt    = alu_result;
            ex_push   = 1'b1;
            ex_rel    = 1'b1;
            ex_ok     = 1'b1;
          end
        end
        CMD_FREE_COUNT: ex_ok = 1'b1;
        default:        ex_ok = 1'b0;
      endcase
    end
  end

  // Memory requests: reads at acceptance, writes in the execute cycle or the clearing pass.
  always_comb begin
    mem_req                  = '0;
    mem_req.rd_en            = ctrl.accept;
    mem_req.cnt_raddr        = IDX_W'(page_i);
    mem_req.link_raddr       = heads_q[rd_sel];
    mem_req.cnt_we           = ctrl.clearing || ex_cnt_we;
    mem_req.cnt_waddr        = ctrl.clearing ? ctrl.clr_addr : ex_cnt_waddr;
    mem_req.cnt_wdata        = alu_result;
    mem_req.link_we          = ex_push;
    mem_req.link_waddr       = IDX_W'(page_q);
    mem_req.link_wdata.valid = sel_nonempty_q;
    mem_req.link_wdata.next  = sel_head_q;
  end

  rpa_store u_store (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .cnt_rdata_o (cnt_rdata),
    .link_rdata_o(link_rdata)
  );

  // Running free total: saturate both ways.
  always_comb begin
    free_total_d = free_total_q;
    if (ex_push && (free_total_q != FREE_MAX)) begin
      free_total_d = free_total_q + 1'b1;
    end else if (ex_pop && (free_total_q != '0)) begin
      free_total_d = free_total_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        heads_q[i] <= '0;
      end
      nonempty_q   <= '0;
      free_total_q <= '0;
    end else begin
      if (ex_pop) begin
        heads_q[sel_q]    <= link_rdata.next;
        nonempty_q[sel_q] <= link_rdata.valid;
      end else if (ex_push) begin
        heads_q[sel_q]    <= IDX_W'(page_q);
        nonempty_q[sel_q] <= 1'b1;
      end
      free_total_q <= free_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= '0;
      page_limit_q <= LIMIT_W'(NUM_PAGES);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FIRST_PAGE: first_page_q <= cfg_wdata_i[FIRST_W-1:0];
        CFG_PAGE_LIMIT: page_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default:        first_page_q <= first_page_q;
      endcase
    end
  end

  // Strobe the result in the cycle after the execute cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.exec) begin
      ok_q         <= ex_ok;
      alloc_page_q <= PAGE_W'(ex_apage);
      ref_count_q  <= REF_W'(ex_cnt);
      released_q   <= ex_rel;
      error_code_q <= ex_err;
    end
  end

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign alloc_page_o = alloc_page_q;
  assign ref_count_o  = ref_count_q;
  assign released_o   = released_q;
  assign free_pages_o = free_total_q;
  assign error_code_o = error_code_q;

  // Every accepted transaction yields its result strobe after its execute state.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  // The block is ready again while a result is shown.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while result is shown");

  // A successful command carries no error code.
  a_ok_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ok_o) |-> (error_code_o == ERR_NONE))
    else $error("ok result with error code");

  // A result never repeats in back-to-back cycles.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

endmodule
